FILE: src/us_pkg.sv
// Shared types and byte-class constants for the UTF-8 stream sanitizer.
package us_pkg;

  localparam logic [7:0] REPL_RESET = 8'h3F;

  localparam logic [7:0] ASCII_HI   = 8'h7F;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;

  // Second-byte limits after the leads that restrict it
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] E0_SEC_LO  = 8'hA0;
  localparam logic [7:0] ED_SEC_HI  = 8'h9F;
  localparam logic [7:0] F0_SEC_LO  = 8'h90;
  localparam logic [7:0] F4_SEC_HI  = 8'h8F;

  localparam logic [2:0] SEQ_LEN2   = 3'd2;
  localparam logic [2:0] SEQ_LEN3   = 3'd3;
  localparam logic [2:0] SEQ_LEN4   = 3'd4;

  localparam int unsigned MAX_RES   = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       run_last;
    logic       stream_end;
  } out_item_t;

  // Results released by one request, entry 0 first
  typedef struct packed {
    logic [2:0]           cnt;
    out_item_t [MAX_RES-1:0] item;
  } us_batch_t;

endpackage

FILE: src/us_decode.sv
// Sequence tracker: holds a started sequence and builds the results of one request.
module us_decode import us_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  in_item_t  req,
  input  logic [7:0] repl,
  output us_batch_t batch
);

  logic [7:0] pend_r   [3];
  logic [7:0] pend_nxt [3];
  logic [1:0] pcnt_r, pcnt_nxt;
  logic [2:0] slen_r, slen_nxt;

  logic [7:0] b;
  logic       fits;
  logic [7:0] lo, hi;

  assign b = req.in_byte;

  // Check the incoming byte against the allowed continuation range
  always_comb begin
    lo = CONT_LO;
    hi = CONT_HI;
    if (pend_r[0] == LEAD_E0) lo = E0_SEC_LO;
    if (pend_r[0] == LEAD_ED) hi = ED_SEC_HI;
    if (pend_r[0] == LEAD_F0) lo = F0_SEC_LO;
    if (pend_r[0] == LEAD_F4) hi = F4_SEC_HI;
    if (pcnt_r == 2'd1) begin
      fits = (b >= lo) && (b <= hi);
    end else begin
      fits = (b & CONT_MASK) == CONT_LO;
    end
  end

  // Build the result list and the next held sequence
  always_comb begin
    out_item_t  res [MAX_RES];
    logic [2:0] n;
    logic       do_start;
    logic       flush_bad;
    logic       cmplt;

    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end
    n         = '0;
    do_start  = 1'b0;
    flush_bad = 1'b0;
    cmplt     = 1'b0;
    pend_nxt  = pend_r;
    pcnt_nxt  = pcnt_r;
    slen_nxt  = slen_r;

    if (pcnt_r == 2'd0) begin
      do_start = 1'b1;
    end else if (!fits) begin
      flush_bad = 1'b1;
      do_start  = 1'b1;
    end else if (({1'b0, pcnt_r} + 3'd1) >= slen_r) begin
      cmplt = 1'b1;
    end

    // Release held bytes, replaced on a break or unchanged on completion
    if (flush_bad || cmplt) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(pcnt_r) && n < 3'(MAX_RES)) begin
          res[n[1:0]].out_byte     = flush_bad ? repl : pend_r[k];
          res[n[1:0]].was_replaced = flush_bad;
          n = n + 3'd1;
        end
      end
      pcnt_nxt = '0;
      slen_nxt = '0;
    end

    // Append the completing byte
    if (cmplt && n < 3'(MAX_RES)) begin
      res[n[1:0]].out_byte = b;
      n = n + 3'd1;
    end

    // Examine the byte as the start of a new sequence
    if (do_start) begin
      if (b <= ASCII_HI) begin
        if (n < 3'(MAX_RES)) begin
          res[n[1:0]].out_byte = b;
          n = n + 3'd1;
        end
      end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
        pend_nxt[0] = b;
        pcnt_nxt    = 2'd1;
        slen_nxt    = SEQ_LEN2;
      end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
        pend_nxt[0] = b;
        pcnt_nxt    = 2'd1;
        slen_nxt    = SEQ_LEN3;
      end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
        pend_nxt[0] = b;
        pcnt_nxt    = 2'd1;
        slen_nxt    = SEQ_LEN4;
      end else if (n < 3'(MAX_RES)) begin
        res[n[1:0]].out_byte     = repl;
        res[n[1:0]].was_replaced = 1'b1;
        n = n + 3'd1;
      end
    end else if (!flush_bad && !cmplt) begin
      // Extend the held sequence
      pend_nxt[pcnt_r] = b;
      pcnt_nxt         = pcnt_r + 2'd1;
    end

    // Release whatever is still held at the end of the stream as replacement bytes
    if (req.in_last) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(pcnt_nxt) && n < 3'(MAX_RES)) begin
          res[n[1:0]].out_byte     = repl;
          res[n[1:0]].was_replaced = 1'b1;
          n = n + 3'd1;
        end
      end
      pcnt_nxt = '0;
      slen_nxt = '0;
    end

    // Mark the last result of this request
    if (n != 3'd0) begin
      res[2'(n - 3'd1)].run_last   = 1'b1;
      res[2'(n - 3'd1)].stream_end = req.in_last;
    end

    batch.cnt = n;
    for (int i = 0; i < MAX_RES; i++) begin
      batch.item[i] = res[i];
    end
  end

  // Hold the sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= '0;
      slen_r <= '0;
    end else if (take) begin
      pcnt_r <= pcnt_nxt;
      slen_r <= slen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: src/us_outq.sv
// Result buffer: loads one batch of up to four results and drains one per cycle while out_ready is high.
module us_outq import us_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  us_batch_t batch,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  ent_r [MAX_RES];
  logic [2:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = ent_r[0];
  assign pop       = out_valid && out_ready;
  // Take a new batch once the buffer empties in this cycle
  assign can_load  = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);

  // Advance the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= batch.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // Load or shift the entries
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        ent_r[i] <= batch.item[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

endmodule

FILE: src/utf8_sanitize_stream_top.sv
// Top level of the UTF-8 stream sanitizer.
// A released result shows on out_* in the cycle after its request is accepted.
// One request per cycle while each releases at most one result and out_ready is high; a
// request that releases more than one result holds in_ready low while the buffer drains.
// Reset (rst_n low, synchronous): no sequence held, buffer empty, replacement byte 0x3F.
module utf8_sanitize_stream_top import us_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] repl_r;
  logic       take;
  us_batch_t  batch;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  // Hold the replacement byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      repl_r <= cfg_data;
    end
  end

  us_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .req   (in_data),
    .repl  (repl_r),
    .batch (batch)
  );

  us_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .batch     (batch),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/us_checker.sv
// Port-level checks for the UTF-8 stream sanitizer, bound to its top level.
module us_checker import us_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input in_item_t   in_data,
  input logic       out_valid,
  input logic       out_ready,
  input out_item_t  out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A marked request always releases a result
  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.in_last |=> out_valid)
    else $error("end of stream released no result");

  // The stream end is the last result of its request
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.run_last)
    else $error("stream_end without run_last");

  // Input stalls only while results wait
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty buffer");

endmodule

bind utf8_sanitize_stream_top us_checker u_us_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 stream sanitizer: directed and random byte streams.
module tb_top;
  import us_pkg::*;

  localparam int unsigned HOLD_CYCLES     = 120;
  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 150;

  // Tracks held sequence bytes and the replacement byte, predicts the released bytes
  class utf8_checker;
    logic [7:0]  repl_byte;
    logic [7:0]  seq_bytes[3];
    int unsigned seq_held;
    int unsigned seq_len;
    out_item_t   expected_q[$];
    out_item_t   released[$];
    int unsigned n_errors;

    function new();
      repl_byte = REPL_RESET;
      seq_held  = 0;
      seq_len   = 0;
      n_errors  = 0;
      foreach (seq_bytes[k]) seq_bytes[k] = '0;
    endfunction

    function void release_byte(logic [7:0] b, bit bad);
      out_item_t r;
      r.out_byte     = bad ? repl_byte : b;
      r.was_replaced = bad;
      r.run_last     = 1'b0;
      r.stream_end   = 1'b0;
      released = {released, r};
    endfunction

    // Release every held byte as replaced and drop the sequence
    function void flush_replaced();
      for (int unsigned k = 0; k < seq_held; k++) release_byte(seq_bytes[k], 1'b1);
      seq_held = 0;
      seq_len  = 0;
    endfunction

    // Examine a byte as the start of a new sequence
    function void open_seq(logic [7:0] b);
      int unsigned len;
      len = 0;
      if (b <= ASCII_HI) begin
        release_byte(b, 1'b0);
        return;
      end
      if (b >= LEAD2_LO && b <= LEAD2_HI) len = 32'(SEQ_LEN2);
      else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 32'(SEQ_LEN3);
      else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 32'(SEQ_LEN4);
      if (len == 0) begin
        release_byte(b, 1'b1);
        return;
      end
      seq_bytes[0] = b;
      seq_held     = 1;
      seq_len      = len;
    endfunction

    // Second byte has lead-specific limits, later ones are plain continuations
    function bit fits(logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = CONT_LO;
      hi = CONT_HI;
      if (seq_held != 1) return (b & CONT_MASK) == CONT_LO;
      case (seq_bytes[0])
        LEAD_E0: lo = E0_SEC_LO;
        LEAD_ED: hi = ED_SEC_HI;
        LEAD_F0: lo = F0_SEC_LO;
        LEAD_F4: hi = F4_SEC_HI;
        default: ;
      endcase
      return b >= lo && b <= hi;
    endfunction

    function void note_request(in_item_t req);
      int unsigned last_idx;
      released.delete();
      if (seq_held == 0) begin
        open_seq(req.in_byte);
      end else if (!fits(req.in_byte)) begin
        flush_replaced();
        open_seq(req.in_byte);
      end else if (seq_held + 1 >= seq_len) begin
        for (int unsigned k = 0; k < seq_held; k++) release_byte(seq_bytes[k], 1'b0);
        release_byte(req.in_byte, 1'b0);
        seq_held = 0;
        seq_len  = 0;
      end else begin
        seq_bytes[seq_held] = req.in_byte;
        seq_held++;
      end
      if (req.in_last) flush_replaced();
      // Mark the final byte of this request and of the stream
      if (released.size() > 0) begin
        last_idx = released.size() - 1;
        released[last_idx].run_last   = 1'b1;
        released[last_idx].stream_end = req.in_last;
      end
      expected_q = {expected_q, released};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result byte=%h replaced=%b run_last=%b end=%b",
                 $time, got.out_byte, got.was_replaced, got.run_last, got.stream_end);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        n_errors++;
        $display("%0t: mismatch expected byte=%h replaced=%b run_last=%b end=%b",
                 $time, want.out_byte, want.was_replaced, want.run_last, want.stream_end);
        $display("%0t:          actual   byte=%h replaced=%b run_last=%b end=%b",
                 $time, got.out_byte, got.was_replaced, got.run_last, got.stream_end);
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = '0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 30;
  bit          hold_req     = 1'b0;
  int unsigned stall_cnt    = 0;
  logic [7:0]  stream_q[$];
  utf8_checker chk = new();

  utf8_sanitize_stream_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Check results and watch for a stalled handshake
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) chk.check_result(out_data);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive out_ready: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offer one request, idling at random first, and predict it once accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t req;
    req.in_byte = b;
    req.in_last = last;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    chk.note_request(req);
  endtask

  // Hold the input until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chk.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_repl(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chk.repl_byte = v;
  endtask

  task automatic send_stream();
    foreach (stream_q[k]) send_byte(stream_q[k], k == stream_q.size() - 1);
  endtask

  // Append one well-formed character of the given length
  function automatic void push_char(int unsigned len);
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    lo = CONT_LO;
    hi = CONT_HI;
    if (len == 1) begin
      stream_q = {stream_q, 8'($urandom_range(0, ASCII_HI))};
      return;
    end
    if (len == SEQ_LEN2) lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
    else if (len == SEQ_LEN3) lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
    else lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
    // favor the leads that narrow the second byte
    if (len > SEQ_LEN2 && $urandom_range(2) == 0) begin
      if (len == SEQ_LEN3) lead = $urandom_range(1) ? LEAD_E0 : LEAD_ED;
      else lead = $urandom_range(1) ? LEAD_F0 : LEAD_F4;
    end
    if (lead == LEAD_E0) lo = E0_SEC_LO;
    if (lead == LEAD_ED) hi = ED_SEC_HI;
    if (lead == LEAD_F0) lo = F0_SEC_LO;
    if (lead == LEAD_F4) hi = F4_SEC_HI;
    stream_q = {stream_q, lead};
    stream_q = {stream_q, 8'($urandom_range(lo, hi))};
    for (int unsigned k = 2; k < len; k++)
      stream_q = {stream_q, 8'($urandom_range(CONT_LO, CONT_HI))};
  endfunction

  // Mostly well-formed characters, some truncated sequences and raw noise
  function automatic void build_stream(int unsigned n);
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    stream_q.delete();
    while (stream_q.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        push_char($urandom_range(1, 4));
      end else if (pick < 88) begin
        len  = $urandom_range(2, 4);
        push_char(len);
        keep = $urandom_range(1, len - 1);
        repeat (len - keep) void'(stream_q.pop_back());
        if ($urandom_range(3) != 0) stream_q = {stream_q, 8'($urandom)};
      end else begin
        stream_q = {stream_q, 8'($urandom)};
      end
    end
  endfunction

  initial begin
    int unsigned sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, bad leads, complete and broken sequences, flush at end
    stream_q = '{8'h00, 8'hFF, 8'h80, 8'hC2, 8'h80, 8'hED, 8'h9F, 8'hBF,
                 8'hF0, 8'h90, 8'h80, 8'h80, 8'hE0, 8'h9F, 8'hF4, 8'h90,
                 8'hE1, 8'h80, 8'h41, 8'hF4, 8'h8F, 8'hBF};
    send_stream();
    stream_q = '{8'hF0, 8'h90, 8'h80, 8'h41};
    send_stream();
    stream_q = '{8'hC2};
    send_stream();

    // Random phases, each under its own replacement byte and idle pattern
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          src_idle_pct = 8;
          snk_idle_pct = 63;
          write_repl(8'h00);
        end
        1: begin
          src_idle_pct = 63;
          snk_idle_pct = 8;
          write_repl(8'hFF);
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          write_repl(8'($urandom_range(1, 254)));
          hold_req = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        build_stream($urandom_range(1, 24));
        send_stream();
        sent += stream_q.size();
      end
    end

    wait_drained();
    if (chk.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
